FILE: sv/farp_pkg.sv
// shared types, constants and fixed-point helpers for the field angle ray projection unit
// no dependencies; imported by every other file of the block
package farp_pkg;

	// fixed-point formats
	localparam int FRAC_BITS      = 15;             // working fraction bits
	localparam int OUT_FRAC       = 15;             // result format Q1.15
	localparam int ANGLE_BITS_DEF = 16;             // binary angle bits per turn
	localparam int W              = FRAC_BITS + 6;  // working width, holds +/-32
	localparam int MW             = W;              // magnitude width for the divider

	// rotator chain
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;               // Q2.30 plus headroom

	// divider chain: 18 quotient bits, overflow sorted out up front
	localparam int DIV_STEPS = 18;
	localparam int QW        = DIV_STEPS;
	localparam int NW        = MW + QW;             // partial remainder width

	// config register indexes
	localparam logic [1:0] REG_RAY_COS_X = 2'd0;
	localparam logic [1:0] REG_RAY_COS_Y = 2'd1;
	localparam logic [1:0] REG_RAY_COS_Z = 2'd2;

	localparam logic [15:0] RAY_VERTICAL = 16'd32767;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

	// arctangent of 2^-i in 2^32 units per turn
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	localparam logic signed [W-1:0]   ONE      = W'(1) <<< FRAC_BITS;
	localparam logic signed [2*W-1:0] MUL_HALF = (2*W)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [W-1:0]   SAT_HI   = W'(32767);
	localparam logic signed [W-1:0]   SAT_LO   = W'(-32768);

	// rotator state
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} rot_t;

	// divider state
	typedef struct packed {
		logic [NW-1:0] rem;
		logic [MW:0]   d;
		logic [QW-1:0] q;
	} div_t;

	// product rounded to nearest, ties toward +inf
	function automatic logic signed [W-1:0] mulf(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		p = p + MUL_HALF;
		return p[FRAC_BITS+W-1:FRAC_BITS];
	endfunction

	// clamp to the signed 16-bit result range
	function automatic logic [15:0] sat16(input logic signed [W-1:0] v);
		logic signed [W-1:0] c;
		if (v > SAT_HI) c = SAT_HI;
		else if (v < SAT_LO) c = SAT_LO;
		else c = v;
		return c[15:0];
	endfunction

endpackage

FILE: sv/field_angle_ray_projection_unit.sv
// top level: field direction projected onto the ray frame, one request per cycle while the output is not stalled
// depends on farp_pkg, farp_rot_cell, farp_div_cell
//
// Usage:
//   Input channel field_valid/field_ready carries one depth point (inclination,
//   azimuth, last_of_column). Output channel result_valid/result_ready carries
//   cos_gamma_ray, cos_two_chi, sin_two_chi, degenerate and last_out.
//   The ray direction cosines are written through wr_en/wr_index/wr_data while
//   the unit is idle; index 3 is ignored.
//   A request passes through 1 pre-rotation stage, 30 rotation cells, 10
//   fixed-point stages, 18 divider cells and 1 output register.
//   Throughput is one request per cycle while the output is not stalled; each
//   rotation cell is a single rotation step, each divider cell a single quotient bit.
//   When the receiver stalls while a result waits unaccepted in the output
//   register, the whole chain holds and field_ready drops; only then does it drop.
//   Reset clears all valid bits and sets the ray to vertical
//   (x = 0, y = 0, z = 32767).
module field_angle_ray_projection_unit
	import farp_pkg::*;
#(
	parameter int ANGLE_BITS = farp_pkg::ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        field_valid,
	output logic        field_ready,
	input  logic [15:0] field_inclination,
	input  logic [15:0] field_azimuth,
	input  logic        last_of_column,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] cos_gamma_ray,
	output logic [15:0] cos_two_chi,
	output logic [15:0] sin_two_chi,
	output logic        degenerate,
	output logic        last_out
);

	localparam int NST = CORDIC_STEPS + DIV_STEPS + 12;
	localparam logic signed [CW-1:0] QTURN = CW'(1) <<< 30;
	localparam logic signed [CW-1:0] HTURN = CW'(1) <<< 31;
	localparam logic signed [CW-1:0] RHALF = CW'(1) <<< (29 - FRAC_BITS);

	logic        [15:0]    ray_x_q, ray_y_q, ray_z_q;
	logic signed [W-1:0]   mx, my, mz;
	logic                  en, fire;
	logic        [NST-1:0] vld_q, last_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_x_q <= '0;
			ray_y_q <= '0;
			ray_z_q <= RAY_VERTICAL;
		end else if (wr_en) begin
			case (wr_index)
				REG_RAY_COS_X: ray_x_q <= wr_data;
				REG_RAY_COS_Y: ray_y_q <= wr_data;
				REG_RAY_COS_Z: ray_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign mx = W'(signed'(ray_x_q)) <<< (FRAC_BITS - OUT_FRAC);
	assign my = W'(signed'(ray_y_q)) <<< (FRAC_BITS - OUT_FRAC);
	assign mz = W'(signed'(ray_z_q)) <<< (FRAC_BITS - OUT_FRAC);

	// global advance: hold everything while a result waits
	assign en          = !vld_q[NST-1] || result_ready;
	assign field_ready = en;
	assign fire        = field_valid && field_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], fire};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[NST-2:0], last_of_column};
		end
	end

	// fold the angle into the right half plane
	function automatic rot_t prerot(input logic [31:0] ph);
		rot_t r;
		r.x    = CORDIC_GAIN;
		r.y    = '0;
		r.z    = CW'(signed'(ph));
		r.flip = 1'b0;
		if (r.z > QTURN) begin
			r.z    = r.z - HTURN;
			r.flip = 1'b1;
		end else if (r.z < -QTURN) begin
			r.z    = r.z + HTURN;
			r.flip = 1'b1;
		end
		return r;
	endfunction

	// unfold and round Q2.30 to working precision
	function automatic logic signed [W-1:0] post(input logic signed [CW-1:0] v,
		input logic flip);
		logic signed [CW-1:0] t;
		t = flip ? -v : v;
		t = t + RHALF;
		return W'(t >>> (30 - FRAC_BITS));
	endfunction

	// pre-rotation register for the three rotators
	logic [31:0] ph_g, ph_c;
	rot_t        rg [CORDIC_STEPS+1];
	rot_t        rc [CORDIC_STEPS+1];
	rot_t        rd [CORDIC_STEPS+1];

	assign ph_g = 32'(field_inclination) << (32 - ANGLE_BITS);
	assign ph_c = 32'(field_azimuth) << (32 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			rg[0] <= prerot(ph_g);
			rc[0] <= prerot(ph_c);
			rd[0] <= prerot(ph_c << 1);
		end
	end

	// rotation cells: inclination, azimuth, doubled azimuth
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		farp_rot_cell #(.STEP(i)) u_g (.clk(clk), .en(en), .d_in(rg[i]), .d_q(rg[i+1]));
		farp_rot_cell #(.STEP(i)) u_c (.clk(clk), .en(en), .d_in(rc[i]), .d_q(rc[i+1]));
		farp_rot_cell #(.STEP(i)) u_d (.clk(clk), .en(en), .d_in(rd[i]), .d_q(rd[i+1]));
	end

	// fixed-point projection stages
	logic signed [W-1:0]     cg_s1, sg_s1, cc_s1, sc_s1, c2v_s1, s2v_s1;
	logic signed [W-1:0]     bx_s2, by_s2, bz_s2;
	logic        [15:0]      vcg_s2, vc2_s2, vs2_s2;
	logic signed [2*W-1:0]   px_s3, py_s3, pz_s3;
	logic signed [W-1:0]     n2a_s3, n2b_s3, bz_s3;
	logic        [15:0]      vcg_s3, vc2_s3, vs2_s3;
	logic signed [W-1:0]     b3_s4, n2_s4, sz_s4, bz_s4;
	logic        [15:0]      vcg_s4, vc2_s4, vs2_s4;
	logic signed [W-1:0]     mzb3_s5, b3b3_s5, b3_s5, n2_s5, sz_s5, bz_s5;
	logic        [15:0]      vcg_s5, vc2_s5, vs2_s5;
	logic signed [W-1:0]     n1_s6, c2_s6, n2_s6, sz_s6, b3_s6;
	logic        [15:0]      vcg_s6, vc2_s6, vs2_s6;
	logic signed [W-1:0]     n11_s7, n22_s7, n12_s7, den_s7, b3_s7;
	logic                    dg_s7;
	logic        [15:0]      vcg_s7, vc2_s7, vs2_s7;
	logic signed [W-1:0]     num1_s8, num2_s8, den_s8, b3_s8;
	logic                    dg_s8;
	logic        [15:0]      vcg_s8, vc2_s8, vs2_s8;
	logic        [MW-1:0]    an1_s9, an2_s9, ad_s9;
	logic                    ng1_s9, ng2_s9, dg_s9;
	logic signed [W-1:0]     b3_s9;
	logic        [15:0]      vcg_s9, vc2_s9, vs2_s9;
	logic signed [2*W+1:0]   bsum;

	assign bsum = (2*W+2)'(px_s3) + (2*W+2)'(py_s3) + (2*W+2)'(pz_s3)
		+ (2*W+2)'(MUL_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			// sine and cosine out of the rotators
			cg_s1  <= post(rg[CORDIC_STEPS].x, rg[CORDIC_STEPS].flip);
			sg_s1  <= post(rg[CORDIC_STEPS].y, rg[CORDIC_STEPS].flip);
			cc_s1  <= post(rc[CORDIC_STEPS].x, rc[CORDIC_STEPS].flip);
			sc_s1  <= post(rc[CORDIC_STEPS].y, rc[CORDIC_STEPS].flip);
			c2v_s1 <= post(rd[CORDIC_STEPS].x, rd[CORDIC_STEPS].flip);
			s2v_s1 <= post(rd[CORDIC_STEPS].y, rd[CORDIC_STEPS].flip);
			// field vector
			bx_s2  <= mulf(sg_s1, cc_s1);
			by_s2  <= mulf(sg_s1, sc_s1);
			bz_s2  <= cg_s1;
			vcg_s2 <= sat16(cg_s1);
			vc2_s2 <= sat16(c2v_s1);
			vs2_s2 <= sat16(s2v_s1);
			// dot product terms and cross terms
			px_s3  <= mx * bx_s2;
			py_s3  <= my * by_s2;
			pz_s3  <= mz * bz_s2;
			n2a_s3 <= mulf(my, bx_s2);
			n2b_s3 <= mulf(mx, by_s2);
			bz_s3  <= bz_s2;
			vcg_s3 <= vcg_s2;
			vc2_s3 <= vc2_s2;
			vs2_s3 <= vs2_s2;
			// line-of-sight cosine
			b3_s4  <= bsum[FRAC_BITS+W-1:FRAC_BITS];
			n2_s4  <= n2a_s3 - n2b_s3;
			sz_s4  <= ONE - mulf(mz, mz);
			bz_s4  <= bz_s3;
			vcg_s4 <= vcg_s3;
			vc2_s4 <= vc2_s3;
			vs2_s4 <= vs2_s3;
			// products with b3
			mzb3_s5 <= mulf(mz, b3_s4);
			b3b3_s5 <= mulf(b3_s4, b3_s4);
			b3_s5   <= b3_s4;
			n2_s5   <= n2_s4;
			sz_s5   <= sz_s4;
			bz_s5   <= bz_s4;
			vcg_s5  <= vcg_s4;
			vc2_s5  <= vc2_s4;
			vs2_s5  <= vs2_s4;
			// n1 and 1 - b3^2
			n1_s6  <= bz_s5 - mzb3_s5;
			c2_s6  <= ONE - b3b3_s5;
			n2_s6  <= n2_s5;
			sz_s6  <= sz_s5;
			b3_s6  <= b3_s5;
			vcg_s6 <= vcg_s5;
			vc2_s6 <= vc2_s5;
			vs2_s6 <= vs2_s5;
			// squares and denominator
			n11_s7 <= mulf(n1_s6, n1_s6);
			n22_s7 <= mulf(n2_s6, n2_s6);
			n12_s7 <= mulf(n1_s6, n2_s6);
			den_s7 <= mulf(sz_s6, c2_s6);
			dg_s7  <= (sz_s6 == '0) || (c2_s6 == '0);
			b3_s7  <= b3_s6;
			vcg_s7 <= vcg_s6;
			vc2_s7 <= vc2_s6;
			vs2_s7 <= vs2_s6;
			// numerators
			num1_s8 <= n11_s7 - n22_s7;
			num2_s8 <= n12_s7 <<< 1;
			den_s8  <= den_s7;
			dg_s8   <= dg_s7 || (den_s7 == '0);
			b3_s8   <= b3_s7;
			vcg_s8  <= vcg_s7;
			vc2_s8  <= vc2_s7;
			vs2_s8  <= vs2_s7;
			// magnitudes and quotient signs
			an1_s9 <= num1_s8[W-1] ? MW'(-num1_s8) : MW'(num1_s8);
			an2_s9 <= num2_s8[W-1] ? MW'(-num2_s8) : MW'(num2_s8);
			ad_s9  <= den_s8[W-1] ? MW'(-den_s8) : MW'(den_s8);
			ng1_s9 <= num1_s8[W-1] != den_s8[W-1];
			ng2_s9 <= num2_s8[W-1] != den_s8[W-1];
			dg_s9  <= dg_s8;
			b3_s9  <= b3_s8;
			vcg_s9 <= vcg_s8;
			vc2_s9 <= vc2_s8;
			vs2_s9 <= vs2_s8;
		end
	end

	// side data carried alongside the divider chain
	typedef struct packed {
		logic                degen;
		logic                neg_c;
		logic                ovf_c;
		logic                neg_s;
		logic                ovf_s;
		logic signed [W-1:0] b3;
		logic        [15:0]  vcg;
		logic        [15:0]  vc2;
		logic        [15:0]  vs2;
	} side_t;

	div_t  dc [DIV_STEPS+1];
	div_t  ds [DIV_STEPS+1];
	side_t sd_q [DIV_STEPS+1];

	// divider setup: rounded quotient of (an*2^16 + ad) / (2*ad)
	always_ff @(posedge clk) begin
		if (en) begin
			dc[0].rem   <= (NW'(an1_s9) << (OUT_FRAC + 1)) + NW'(ad_s9);
			dc[0].d     <= {ad_s9, 1'b0};
			dc[0].q     <= '0;
			ds[0].rem   <= (NW'(an2_s9) << (OUT_FRAC + 1)) + NW'(ad_s9);
			ds[0].d     <= {ad_s9, 1'b0};
			ds[0].q     <= '0;
			sd_q[0].degen <= dg_s9;
			sd_q[0].neg_c <= ng1_s9;
			sd_q[0].ovf_c <= (MW+2)'(an1_s9) >= {ad_s9, 2'b00};
			sd_q[0].neg_s <= ng2_s9;
			sd_q[0].ovf_s <= (MW+2)'(an2_s9) >= {ad_s9, 2'b00};
			sd_q[0].b3    <= b3_s9;
			sd_q[0].vcg   <= vcg_s9;
			sd_q[0].vc2   <= vc2_s9;
			sd_q[0].vs2   <= vs2_s9;
		end
	end

	// divider cells, most significant quotient bit first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		farp_div_cell #(.K(DIV_STEPS - 1 - k)) u_c (
			.clk(clk), .en(en), .d_in(dc[k]), .d_q(dc[k+1]));
		farp_div_cell #(.K(DIV_STEPS - 1 - k)) u_s (
			.clk(clk), .en(en), .d_in(ds[k]), .d_q(ds[k+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				sd_q[k+1] <= sd_q[k];
			end
		end
	end

	// signed, saturated quotient
	function automatic logic [15:0] fin(input logic [QW-1:0] q, input logic neg,
		input logic ovf);
		logic [15:0] r;
		if (neg) begin
			if (ovf || q > QW'(32768)) r = 16'h8000;
			else r = 16'(-q);
		end else begin
			if (ovf || q > QW'(32767)) r = 16'h7FFF;
			else r = q[15:0];
		end
		return r;
	endfunction

	side_t sfin;
	assign sfin = sd_q[DIV_STEPS];

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (ray_z_q == RAY_VERTICAL) begin
				cos_gamma_ray <= sfin.vcg;
				cos_two_chi   <= sfin.vc2;
				sin_two_chi   <= sfin.vs2;
				degenerate    <= 1'b0;
			end else if (sfin.degen) begin
				cos_gamma_ray <= '0;
				cos_two_chi   <= '0;
				sin_two_chi   <= '0;
				degenerate    <= 1'b1;
			end else begin
				cos_gamma_ray <= sat16(sfin.b3);
				cos_two_chi   <= fin(dc[DIV_STEPS].q, sfin.neg_c, sfin.ovf_c);
				sin_two_chi   <= fin(ds[DIV_STEPS].q, sfin.neg_s, sfin.ovf_s);
				degenerate    <= 1'b0;
			end
		end
	end

	assign result_valid = vld_q[NST-1];
	assign last_out     = last_q[NST-1];

endmodule

FILE: sv/farp_rot_cell.sv
// one rotation step of the sine/cosine chain, registered
// depends on farp_pkg (rot_t, ATAN_TAB)
module farp_rot_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  farp_pkg::rot_t d_in,
	output farp_pkg::rot_t d_q
);
	import farp_pkg::*;

	localparam logic signed [CW-1:0] ANG = signed'(CW'(ATAN_TAB[STEP]));

	rot_t nxt;

	// rotate toward zero residual angle
	always_comb begin
		nxt.flip = d_in.flip;
		if (!d_in.z[CW-1]) begin
			nxt.x = d_in.x - (d_in.y >>> STEP);
			nxt.y = d_in.y + (d_in.x >>> STEP);
			nxt.z = d_in.z - ANG;
		end else begin
			nxt.x = d_in.x + (d_in.y >>> STEP);
			nxt.y = d_in.y - (d_in.x >>> STEP);
			nxt.z = d_in.z + ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule

FILE: sv/farp_div_cell.sv
// one restoring quotient bit of the divider chain, registered
// depends on farp_pkg (div_t)
module farp_div_cell #(
	parameter int K = 0
) (
	input  logic           clk,
	input  logic           en,
	input  farp_pkg::div_t d_in,
	output farp_pkg::div_t d_q
);
	import farp_pkg::*;

	logic [NW-1:0] dsh;
	div_t          nxt;

	// trial subtract of the shifted divisor
	always_comb begin
		dsh = NW'(d_in.d) << K;
		nxt = d_in;
		if (d_in.rem >= dsh) begin
			nxt.rem  = d_in.rem - dsh;
			nxt.q[K] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule

FILE: dv/farp_checker.sv
// result checker for the field angle ray projection unit: predicts and compares
// depends on farp_pkg (rotator constants, register indexes)
`timescale 1ns / 100ps
module farp_checker
	import farp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        field_valid,
	input  logic        field_ready,
	input  logic [15:0] field_inclination,
	input  logic [15:0] field_azimuth,
	input  logic        last_of_column,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [15:0] cos_gamma_ray,
	input  logic [15:0] cos_two_chi,
	input  logic [15:0] sin_two_chi,
	input  logic        degenerate,
	input  logic        last_out,
	output int          mismatches,
	output int          pending
);

	typedef struct {
		logic [15:0] cg;
		logic [15:0] c2;
		logic [15:0] s2;
		logic        degen;
		logic        last;
	} projection_t;

	projection_t projections_due[$];
	logic [15:0] ray_x, ray_y, ray_z;

	assign pending = projections_due.size();

	// product rounded to nearest, ties toward +inf
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// rotator: phase in 2^32 per turn, results in Q15
	function automatic void turn_sincos(input longint phase, output longint c,
		output longint s);
		longint z, x, y, nx;
		bit flip;
		z = phase & 64'hFFFF_FFFF;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z >= (64'sd1 <<< 31)) z -= 64'sd1 <<< 32;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + (64'sd1 <<< 14)) >>> 15;
		s = (y + (64'sd1 <<< 14)) >>> 15;
	endfunction

	// quotient in Q1.15, half away from zero, saturated
	function automatic longint q15_div(input longint num, input longint den);
		longint an, ad, q;
		bit neg;
		neg = (num < 0) != (den < 0);
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = ((an <<< 16) + ad) / (2 * ad);
		if (neg) return q > 32768 ? -32768 : -q;
		return q > 32767 ? 32767 : q;
	endfunction

	function automatic projection_t project_field(input logic [15:0] incl,
		input logic [15:0] azim, input logic last);
		projection_t r;
		longint pg, pc, cg, sg, cc, sc, c2, s2, mx, my, mz;
		longint bx, by, b3, n1, n2, sz, cb, den;
		pg = longint'(incl) << 16;
		pc = longint'(azim) << 16;
		r = '{default: '0};
		r.last = last;
		turn_sincos(pg, cg, sg);
		if (ray_z == RAY_VERTICAL) begin
			turn_sincos(pc * 2, c2, s2);
			r.cg = 16'(clamp16(cg));
			r.c2 = 16'(clamp16(c2));
			r.s2 = 16'(clamp16(s2));
		end else begin
			mx = longint'($signed(ray_x));
			my = longint'($signed(ray_y));
			mz = longint'($signed(ray_z));
			turn_sincos(pc, cc, sc);
			bx = fx_mul(sg, cc);
			by = fx_mul(sg, sc);
			b3 = (mx * bx + my * by + mz * cg + (64'sd1 <<< 14)) >>> 15;
			n1 = cg - fx_mul(mz, b3);
			n2 = fx_mul(my, bx) - fx_mul(mx, by);
			sz = (64'sd1 <<< FRAC_BITS) - fx_mul(mz, mz);
			cb = (64'sd1 <<< FRAC_BITS) - fx_mul(b3, b3);
			den = fx_mul(sz, cb);
			if (sz == 0 || cb == 0 || den == 0) begin
				r.degen = 1;
			end else begin
				r.cg = 16'(clamp16(b3));
				r.c2 = 16'(q15_div(fx_mul(n1, n1) - fx_mul(n2, n2), den));
				r.s2 = 16'(q15_div(2 * fx_mul(n1, n2), den));
			end
		end
		return r;
	endfunction

	// track the ray registers, predict on each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		projection_t e;
		if (!arst_n) begin
			ray_x <= 16'd0;
			ray_y <= 16'd0;
			ray_z <= RAY_VERTICAL;
			projections_due.delete();
			mismatches <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_RAY_COS_X: ray_x <= wr_data;
					REG_RAY_COS_Y: ray_y <= wr_data;
					REG_RAY_COS_Z: ray_z <= wr_data;
					default: ;
				endcase
			end
			if (field_valid && field_ready)
				projections_due.push_back(project_field(field_inclination, field_azimuth,
					last_of_column));
			if (result_valid && result_ready) begin
				if (projections_due.size() == 0) begin
					if (mismatches < 10)
						$display("checker: result with nothing expected");
					mismatches <= mismatches + 1;
				end else begin
					e = projections_due.pop_front();
					if (e.cg !== cos_gamma_ray || e.c2 !== cos_two_chi
						|| e.s2 !== sin_two_chi || e.degen !== degenerate
						|| e.last !== last_out) begin
						if (mismatches < 10)
							$display("checker: mismatch exp %h %h %h %b %b got %h %h %h %b %b",
								e.cg, e.c2, e.s2, e.degen, e.last, cos_gamma_ray,
								cos_two_chi, sin_two_chi, degenerate, last_out);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

FILE: dv/testbench.sv
// top of the testbench: clock, reset, ray settings and field requests
// depends on farp_pkg, field_angle_ray_projection_unit and farp_checker
`timescale 1ns / 100ps
module testbench;
	import farp_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        wr_en = 0;
	logic [1:0]  wr_index = REG_RAY_COS_X;
	logic [15:0] wr_data = '0;
	logic        field_valid = 0;
	logic        field_ready;
	logic [15:0] field_inclination = '0;
	logic [15:0] field_azimuth = '0;
	logic        last_of_column = 0;
	logic        result_valid;
	logic        result_ready = 0;
	logic [15:0] cos_gamma_ray, cos_two_chi, sin_two_chi;
	logic        degenerate, last_out;
	int          mismatches, pending;
	bit          steady = 0;
	bit          long_hold = 0;
	logic [15:0] ray_set [9][3];

	field_angle_ray_projection_unit i_dut (.*);
	farp_checker i_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_ready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			n = steady ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				result_ready <= 0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1;
			while (!(result_valid && result_ready)) @(posedge clk);
		end
	end

	task automatic send_field(input logic [15:0] incl, input logic [15:0] azim,
		input logic last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			field_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		field_valid <= 1;
		field_inclination <= incl;
		field_azimuth <= azim;
		last_of_column <= last;
		@(posedge clk);
		while (!field_ready) @(posedge clk);
	endtask

	task automatic drain();
		field_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
	endtask

	initial begin
		ray_set = '{
			'{16'd0, 16'd0, RAY_VERTICAL},
			'{16'd0, 16'd0, 16'h8000},
			'{16'd32767, 16'd0, 16'd0},
			'{16'd0, 16'h8000, 16'd0},
			'{16'd23170, 16'd0, 16'd23170},
			'{16'h8000, 16'h8000, 16'h8000},
			'{16'd0, 16'd0, 16'd32766},
			'{16'd0, 16'd0, 16'd0},
			'{16'd18918, 16'hB626, 16'd18918}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(REG_SPARE, 16'h1234);
		for (int p = 0; p < 9; p++) begin
			if (p > 0) drain();
			if (p == 7)
				for (int k = 0; k < 3; k++) ray_set[p][k] = 16'($urandom);
			write_reg(REG_RAY_COS_X, ray_set[p][0]);
			write_reg(REG_RAY_COS_Y, ray_set[p][1]);
			write_reg(REG_RAY_COS_Z, ray_set[p][2]);
			// angle extremes and quadrant edges
			if (p == 0 || p == 2 || p == 4) begin
				send_field(16'h0000, 16'h0000, 0);
				send_field(16'hFFFF, 16'hFFFF, 1);
				send_field(16'h4000, 16'h0000, 0);
				send_field(16'h4000, 16'h4000, 0);
				send_field(16'h8000, 16'h8000, 1);
				send_field(16'hC000, 16'h2000, 0);
				send_field(16'h2000, 16'hE000, 0);
				send_field(16'h5555, 16'hAAAA, 1);
			end
			if (p == 3) long_hold = 1;
			for (int i = 0; i < 210; i++) begin
				if (i % 50 == 0) steady = ($urandom_range(0, 2) == 0);
				send_field(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
			end
			steady = 0;
		end
		drain();
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
